// File: src/tctq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctq_pkg
// Types and constants shared by the two-class timeout queue.
// ----------------------------------------------------------------------------
package tctq_pkg;

  localparam int DEFAULT_LIST_DEPTH = 16;
  localparam int CHANNELS           = 256;
  localparam logic [23:0] SHORT_DELAY_RESET = 24'd60;
  localparam logic [23:0] LONG_DELAY_RESET  = 24'd172800;

  typedef enum logic [1:0] {
    CMD_SCHED_SHORT = 2'd0,
    CMD_SCHED_LONG  = 2'd1,
    CMD_CANCEL      = 2'd2,
    CMD_TICK        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_EXPIRED     = 3'd0,
    KIND_DONE        = 3'd1,
    KIND_PENDING     = 3'd2,
    KIND_FULL        = 3'd3,
    KIND_NOT_PENDING = 3'd4
  } kind_t;

  typedef enum logic {
    REG_SHORT_DELAY = 1'b0,
    REG_LONG_DELAY  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_SCHED  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE   = 2'd0,
    B_TICK_S = 2'd1,
    B_TICK_L = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  channel;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  channel_res;
    logic        which_list;
    logic        last;
  } out_item_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic        lst;
    logic        bad_ch;
    logic [7:0]  channel;
    logic [31:0] now;
  } op_item_t;

  typedef struct packed {
    logic     valid;
    op_item_t item;
  } op_head_t;

endpackage

// File: src/two_class_timeout_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_timeout_queue
// Short and long timeout lists of channel handles with schedule, cancel
// and tick requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The front end
// decodes it into a two-entry queue; busy is high only while that queue is
// full. The back end executes one request at a time from the queue.
// Schedule and cancel are carried out in the back end's idle state; when
// the back end is free, a request passes through the queue and then the
// res register. A tick takes the back end from its idle state through the
// short-list and long-list states: it takes the request, checks the head
// of the short list, then the long list, one entry per cycle, and each
// expired entry leaves as its own result. Every request ends with a result
// that has last set. Results appear on res for one cycle with res_valid
// high; the receiver cannot stall them. Delay registers are written
// through cfg_we, cfg_index and cfg_data. Reset empties both lists and the
// queue and restores the delays to 60 and 172800 seconds.
// ----------------------------------------------------------------------------
module two_class_timeout_queue #(
  parameter int LIST_DEPTH = tctq_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tctq_pkg::in_item_t  req,
  output logic                busy,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  output logic                res_valid,
  output tctq_pkg::out_item_t res
);
  import tctq_pkg::*;

  op_head_t head;
  logic     pop;

  tctq_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .head  (head),
    .pop   (pop)
  );

  tctq_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

// File: src/tctq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctq_front
// Accepts requests, decodes and range-checks them, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tctq_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tctq_pkg::in_item_t req,
  output logic               busy,
  output tctq_pkg::op_head_t head,
  input  logic               pop
);
  import tctq_pkg::*;

  op_item_t   q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  op_item_t   cls;

  always_comb begin
    cls.channel = req.channel;
    cls.now     = req.now;
    cls.bad_ch  = ({5'd0, req.channel} >= 13'(CHANNELS));
    cls.lst     = 1'b0;
    case (cmd_t'(req.command))
      CMD_SCHED_SHORT: cls.op = OP_SCHED;
      CMD_SCHED_LONG: begin
        cls.op  = OP_SCHED;
        cls.lst = 1'b1;
      end
      CMD_CANCEL: cls.op = OP_CANCEL;
      default: cls.op = OP_TICK;
    endcase
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && head.valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop && head.valid);
    end
  end

endmodule

// File: src/tctq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctq_back
// Holds the two timeout lists and the delay registers, and carries out
// schedule, cancel and tick requests one at a time.
// ----------------------------------------------------------------------------
module tctq_back #(
  parameter int LIST_DEPTH = tctq_pkg::DEFAULT_LIST_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  tctq_pkg::op_head_t  head,
  output logic                pop,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  output logic                res_valid,
  output tctq_pkg::out_item_t res
);
  import tctq_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = $clog2(LIST_DEPTH);

  logic [7:0]    hnd [2][LIST_DEPTH];
  logic [32:0]   exq [2][LIST_DEPTH];
  logic [CW-1:0] cnt [2];
  logic [23:0]   short_delay;
  logic [23:0]   long_delay;
  logic [31:0]   tnow;

  back_state_t state, state_next;
  logic        hit [2];
  logic [IW-1:0] pos [2];

  logic        rm_en, rm_lst;
  logic [IW-1:0] rm_pos;
  logic        ap_en, ap_lst;
  logic [32:0] ap_exp;
  logic        res_valid_next;
  out_item_t   res_next;
  logic        tl;

  // Parallel lookup of the request's channel in both lists.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hit[l] = 1'b0;
      pos[l] = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (!hit[l] && (CW'(i) < cnt[l]) && (hnd[l][i] == head.item.channel)) begin
          hit[l] = 1'b1;
          pos[l] = IW'(i);
        end
      end
    end
  end

  always_comb begin
    state_next     = state;
    pop            = 1'b0;
    rm_en          = 1'b0;
    rm_lst         = 1'b0;
    rm_pos         = '0;
    ap_en          = 1'b0;
    ap_lst         = head.item.lst;
    ap_exp         = {1'b0, head.item.now}
                     + {9'd0, (head.item.lst ? long_delay : short_delay)};
    res_valid_next = 1'b0;
    res_next.kind        = KIND_DONE;
    res_next.channel_res = head.item.channel;
    res_next.which_list  = 1'b0;
    res_next.last        = 1'b1;
    tl             = (state == B_TICK_L);
    case (state)
      B_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.item.op)
            OP_SCHED: begin
              res_valid_next      = 1'b1;
              res_next.which_list = head.item.lst;
              if (head.item.bad_ch) begin
                res_next.kind = KIND_FULL;
              end else if (hit[0] || hit[1]) begin
                res_next.kind       = KIND_PENDING;
                res_next.which_list = !hit[0];
              end else if (cnt[head.item.lst] == CW'(LIST_DEPTH)) begin
                res_next.kind = KIND_FULL;
              end else begin
                ap_en = 1'b1;
              end
            end
            OP_CANCEL: begin
              res_valid_next = 1'b1;
              if (head.item.bad_ch || !(hit[0] || hit[1])) begin
                res_next.kind = KIND_NOT_PENDING;
              end else begin
                rm_en               = 1'b1;
                rm_lst              = !hit[0];
                rm_pos              = hit[0] ? pos[0] : pos[1];
                res_next.which_list = !hit[0];
              end
            end
            default: begin
              state_next = B_TICK_S;
            end
          endcase
        end
      end
      B_TICK_S, B_TICK_L: begin
        if ((cnt[tl] != '0) && ({1'b0, tnow} >= exq[tl][0])) begin
          res_valid_next       = 1'b1;
          res_next.kind        = KIND_EXPIRED;
          res_next.channel_res = hnd[tl][0];
          res_next.which_list  = tl;
          res_next.last        = 1'b0;
          rm_en                = 1'b1;
          rm_lst               = tl;
        end else if (!tl) begin
          state_next = B_TICK_L;
        end else begin
          res_valid_next       = 1'b1;
          res_next.channel_res = 8'd0;
          state_next           = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // List storage: append at the tail, remove with the later entries moving up.
  always_ff @(posedge clk) begin
    if (ap_en) begin
      hnd[ap_lst][cnt[ap_lst][IW-1:0]] <= head.item.channel;
      exq[ap_lst][cnt[ap_lst][IW-1:0]] <= ap_exp;
    end
    if (rm_en) begin
      for (int i = 0; i < LIST_DEPTH - 1; i++) begin
        if (i >= int'(rm_pos)) begin
          hnd[rm_lst][i] <= hnd[rm_lst][i+1];
          exq[rm_lst][i] <= exq[rm_lst][i+1];
        end
      end
    end
    if (state == B_IDLE) begin
      tnow <= head.item.now;
    end
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      cnt[0]      <= '0;
      cnt[1]      <= '0;
      res_valid   <= 1'b0;
      short_delay <= SHORT_DELAY_RESET;
      long_delay  <= LONG_DELAY_RESET;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      if (ap_en) begin
        cnt[ap_lst] <= cnt[ap_lst] + CW'(1);
      end
      if (rm_en) begin
        cnt[rm_lst] <= cnt[rm_lst] - CW'(1);
      end
      if (cfg_we) begin
        if (reg_idx_t'(cfg_index) == REG_SHORT_DELAY) begin
          short_delay <= cfg_data;
        end else begin
          long_delay <= cfg_data;
        end
      end
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_timeout_queue testbench
// Drives schedule, cancel and tick requests and delay register writes into
// the timeout queue, predicts every status and expiry result from its own
// model of both lists, and checks each result in order as it appears.
// ----------------------------------------------------------------------------
module testbench;
  import tctq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int DRAIN_WAIT  = 48;
  localparam int CYCLE_LIMIT = 200000;

  class timeout_scoreboard;
    logic [7:0]  handles [2][DEPTH];
    logic [32:0] expiries[2][DEPTH];
    int          fill[2];
    bit          pending[256];
    logic [23:0] delay[2];
    out_item_t   expected_results[$];
    int          errors;

    function new();
      fill[0]  = 0;
      fill[1]  = 0;
      delay[0] = SHORT_DELAY_RESET;
      delay[1] = LONG_DELAY_RESET;
      errors   = 0;
      foreach (pending[i]) pending[i] = 0;
    endfunction

    function void set_delay(reg_idx_t idx, logic [23:0] value);
      delay[idx == REG_LONG_DELAY] = value;
    endfunction

    function void add_result(kind_t k, logic [7:0] ch, logic lst, logic is_last);
      out_item_t r;
      r.kind        = k;
      r.channel_res = ch;
      r.which_list  = lst;
      r.last        = is_last;
      expected_results.push_back(r);
    endfunction

    function int find_pos(int lst, logic [7:0] ch);
      for (int i = 0; i < fill[lst]; i++) if (handles[lst][i] == ch) return i;
      return -1;
    endfunction

    function void remove_at(int lst, int pos);
      for (int i = pos; i < fill[lst] - 1; i++) begin
        handles[lst][i]  = handles[lst][i + 1];
        expiries[lst][i] = expiries[lst][i + 1];
      end
      fill[lst]--;
    endfunction

    // Works out the results of one accepted request and updates the lists.
    function void note_request(in_item_t rq);
      int lst;
      int pos;
      case (cmd_t'(rq.command))
        CMD_SCHED_SHORT, CMD_SCHED_LONG: begin
          lst = (rq.command == CMD_SCHED_LONG);
          if (pending[rq.channel]) begin
            add_result(KIND_PENDING, rq.channel, find_pos(0, rq.channel) < 0, 1'b1);
          end else if (fill[lst] >= DEPTH) begin
            add_result(KIND_FULL, rq.channel, 1'(lst), 1'b1);
          end else begin
            handles[lst][fill[lst]]  = rq.channel;
            expiries[lst][fill[lst]] = {1'b0, rq.now} + {9'd0, delay[lst]};
            fill[lst]++;
            pending[rq.channel] = 1;
            add_result(KIND_DONE, rq.channel, 1'(lst), 1'b1);
          end
        end
        CMD_CANCEL: begin
          pos = pending[rq.channel] ? find_pos(0, rq.channel) : -1;
          if (!pending[rq.channel]) begin
            add_result(KIND_NOT_PENDING, rq.channel, 1'b0, 1'b1);
          end else if (pos >= 0) begin
            remove_at(0, pos);
            pending[rq.channel] = 0;
            add_result(KIND_DONE, rq.channel, 1'b0, 1'b1);
          end else begin
            pos = find_pos(1, rq.channel);
            pending[rq.channel] = 0;
            if (pos >= 0) begin
              remove_at(1, pos);
              add_result(KIND_DONE, rq.channel, 1'b1, 1'b1);
            end else begin
              add_result(KIND_NOT_PENDING, rq.channel, 1'b0, 1'b1);
            end
          end
        end
        default: begin
          for (int l = 0; l < 2; l++) begin
            while (fill[l] > 0 && {1'b0, rq.now} >= expiries[l][0]) begin
              pending[handles[l][0]] = 0;
              add_result(KIND_EXPIRED, handles[l][0], 1'(l), 1'b0);
              remove_at(l, 0);
            end
          end
          add_result(KIND_DONE, 8'd0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind mismatch, expected %0d, actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.channel_res !== want.channel_res) begin
        $display("%0t: channel mismatch, expected %0d, actual %0d",
                 $time, want.channel_res, got.channel_res);
        errors++;
      end
      if (got.which_list !== want.which_list) begin
        $display("%0t: list mismatch, expected %0d, actual %0d",
                 $time, want.which_list, got.which_list);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %0d, actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_item_t    req = '0;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;
  logic        res_valid;
  out_item_t   res;

  timeout_scoreboard sb = new();
  int          accepted_count = 0;
  int          cycle_count = 0;
  logic [31:0] clock_now = 0;
  bit          gaps_on = 1;

  two_class_timeout_queue u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_valid(res_valid), .res(res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_request(req);
        accepted_count++;
      end
      if (res_valid) sb.check_result(res);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_class_timeout_queue regression: fail");
      $finish;
    end
  end

  // Holds start high until the request is taken; the caller decides whether
  // start drops afterward.
  task automatic send_request(cmd_t cmd, logic [7:0] ch, logic [31:0] t);
    int seen;
    seen = accepted_count;
    start = 1'b1;
    req.command = cmd;
    req.channel = ch;
    req.now = t;
    do @(negedge clk); while (accepted_count == seen);
  endtask

  task automatic idle_gap();
    int pick;
    int len;
    pick = $urandom_range(99);
    len = !gaps_on || pick < 60 ? 0 : (pick < 90 ? $urandom_range(3, 1) : $urandom_range(40, 5));
    if (len > 0) begin
      start = 1'b0;
      req = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
      repeat (len) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_delay(reg_idx_t idx, logic [23:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    sb.set_delay(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = 24'($urandom);
  endtask

  task automatic random_requests(int count);
    int pick;
    cmd_t cmd;
    logic [7:0] ch;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      cmd = pick < 35 ? CMD_SCHED_SHORT : pick < 60 ? CMD_SCHED_LONG :
            pick < 80 ? CMD_CANCEL : CMD_TICK;
      // A small pool of channels makes repeats, cancels of live entries and
      // full lists common.
      ch = $urandom_range(99) < 75 ? 8'($urandom_range(23)) : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 5) clock_now = $urandom;
      else if (pick < 10) clock_now = 32'hffff_ffff - $urandom_range(3);
      else clock_now = clock_now + $urandom_range(pick < 30 ? 200000 : 80);
      send_request(cmd, ch, clock_now);
      idle_gap();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: repeats, cancels, expiry past the time range and bit patterns.
    send_request(CMD_SCHED_SHORT, 8'd0, 32'd0);
    send_request(CMD_SCHED_SHORT, 8'd0, 32'd5);
    send_request(CMD_SCHED_LONG, 8'd0, 32'd5);
    send_request(CMD_CANCEL, 8'd255, 32'd0);
    send_request(CMD_SCHED_LONG, 8'd255, 32'hffff_ffff);
    send_request(CMD_SCHED_LONG, 8'd170, 32'd10);
    send_request(CMD_SCHED_SHORT, 8'h55, 32'h5555_5555);
    send_request(CMD_TICK, 8'haa, 32'd59);
    send_request(CMD_TICK, 8'h55, 32'd60);
    send_request(CMD_TICK, 8'hff, 32'hffff_ffff);
    send_request(CMD_CANCEL, 8'd255, 32'haaaa_aaaa);
    send_request(CMD_TICK, 8'd0, 32'hffff_ffff);
    send_request(CMD_CANCEL, 8'd0, 32'd0);
    send_request(CMD_SCHED_SHORT, 8'haa, 32'haaaa_aaaa);
    send_request(CMD_TICK, 8'd0, 32'd0);
    for (int i = 0; i < 8; i++) send_request(CMD_SCHED_SHORT, 8'(100 + i), 32'd1000);
    wait_idle();

    // Zero delay expires at once; the long list gets the widest delay.
    write_delay(REG_SHORT_DELAY, 24'd0);
    write_delay(REG_LONG_DELAY, 24'hff_ffff);
    random_requests(30);
    wait_idle();

    gaps_on = 0;
    write_delay(REG_SHORT_DELAY, 24'd1);
    write_delay(REG_LONG_DELAY, 24'd1);
    random_requests(25);
    wait_idle();

    gaps_on = 1;
    write_delay(REG_SHORT_DELAY, 24'hff_ffff);
    write_delay(REG_LONG_DELAY, 24'd0);
    random_requests(25);
    wait_idle();

    write_delay(REG_SHORT_DELAY, 24'($urandom_range(300, 1)));
    write_delay(REG_LONG_DELAY, 24'($urandom));
    random_requests(27);
    wait_idle();

    if (sb.errors == 0) begin
      $display("two_class_timeout_queue regression: pass");
    end else begin
      $display("two_class_timeout_queue regression: fail");
    end
    $finish;
  end
endmodule
